FILE: design/skid_steer_wheel_speed_mixer_macros.svh
// Assertion macros used by the checker file.
`ifndef SKID_STEER_WHEEL_SPEED_MIXER_MACROS_SVH
`define SKID_STEER_WHEEL_SPEED_MIXER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequence checked in the cycle after the antecedent holds.
`define SSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ssm_pkg.sv
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int DIV_STEPS  = 19;
    localparam int FRONT_REGS = 8;
    localparam int NUM_STAGES = FRONT_REGS + DIV_STEPS;

    typedef enum logic [2:0] {
        REG_MAX_FORWARD_SPEED = 3'd0,
        REG_MAX_TURN_RATE     = 3'd1,
        REG_TRACK_GAIN        = 3'd2,
        REG_RPM_GAIN          = 3'd3,
        REG_WHEEL_RPM_LIMIT   = 3'd4
    } ssm_reg_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [18:0] word;
        logic        neg;
    } ssm_div_lane_t;

    function automatic ssm_div_lane_t ssm_div_step(ssm_div_lane_t lane, logic [31:0] divisor);
        logic [32:0]   trial;
        logic [32:0]   diff;
        logic          ge;
        ssm_div_lane_t res;
        trial    = {lane.rem, lane.word[18]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        res.rem  = ge ? diff[31:0] : trial[31:0];
        res.word = {lane.word[17:0], ge};
        res.neg  = lane.neg;
        return res;
    endfunction

    function automatic logic signed [15:0] ssm_clamp(logic signed [15:0] v, logic [14:0] lim);
        logic signed [16:0] vs;
        logic signed [16:0] hi;
        logic signed [16:0] lo;
        logic signed [16:0] r;
        vs = {v[15], v};
        hi = $signed({2'b00, lim});
        lo = 17'sd0 - hi;
        if (vs > hi)
        begin
            r = hi;
        end
        else if (vs < lo)
        begin
            r = lo;
        end
        else
        begin
            r = vs;
        end
        return r[15:0];
    endfunction

endpackage

FILE: design/skid_steer_wheel_speed_mixer.sv
`timescale 1ns / 1ps
// Skid-steer wheel speed mixer.
// Input channel: in_valid / in_stall carry forward_speed and turn_rate; a
// request is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry right_wheel_rpm, left_wheel_rpm
// and was_scaled; one result per request, in request order.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 forward clamp, 1 turn clamp, 2 track gain, 3 rpm gain, 4 rpm limit);
// other indexes are ignored. Write only while no request is in flight.
// Pipeline: a request passes 8 front stages, the first loaded at the
// accepting edge, then 19 restoring divider stages and the output register.
// Throughput: one request per cycle while in_stall is low, set by the one-bit-per-stage divider.
// Reset: all pipeline and output valids clear, registers return to their
// reset values (full clamps, unit gains, largest rpm limit).
// Stall: a one-entry skid buffer beside the output register absorbs one
// result; once both hold results the pipeline freezes and in_stall goes high
// until the receiver takes a result.
module skid_steer_wheel_speed_mixer
    import ssm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] forward_speed,
    input  logic signed [15:0] turn_rate,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [19:0] right_wheel_rpm,
    output logic signed [19:0] left_wheel_rpm,
    output logic               was_scaled,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    logic [14:0] max_forward_speed_reg;
    logic [14:0] max_turn_rate_reg;
    logic [15:0] track_gain_reg;
    logic [23:0] rpm_gain_reg;
    logic [18:0] wheel_rpm_limit_reg;

    logic [NUM_STAGES-1:0] v_reg;
    logic                  en;
    logic                  in_accept;

    logic signed [15:0] s1_f_reg, s1_t_reg, s1_f_next, s1_t_next;
    logic signed [15:0] s2_f_reg;
    logic signed [32:0] s2_diff_reg, s2_diff_next;
    logic [31:0]        s3_mr_reg, s3_ml_reg, s3_mr_next, s3_ml_next;
    logic               s3_nr_reg, s3_nl_reg, s3_nr_next, s3_nl_next;
    logic [55:0]        s4_pr_reg, s4_pl_reg, s4_pr_next, s4_pl_next;
    logic               s4_nr_reg, s4_nl_reg;
    logic [31:0]        s5_rm_reg, s5_lm_reg, s5_rm_next, s5_lm_next;
    logic               s5_nr_reg, s5_nl_reg;
    logic [31:0]        s6_rm_reg, s6_lm_reg, s6_big_reg, s6_big_next;
    logic               s6_nr_reg, s6_nl_reg, s6_sc_reg, s6_sc_next;
    logic [50:0]        s7_pr_reg, s7_pl_reg, s7_pr_next, s7_pl_next;
    logic [31:0]        s7_rm_reg, s7_lm_reg, s7_big_reg;
    logic               s7_nr_reg, s7_nl_reg, s7_sc_reg;

    ssm_div_lane_t      div_r_reg [0:DIV_STEPS];
    ssm_div_lane_t      div_l_reg [0:DIV_STEPS];
    logic               div_sc_reg [0:DIV_STEPS];
    logic [31:0]        div_d_reg [0:DIV_STEPS-1];
    ssm_div_lane_t      div_r_next, div_l_next;
    logic [31:0]        div_d_next;

    logic signed [19:0] res_right, res_left;
    logic               res_push, out_take;

    logic               out_valid_reg, out_valid_next;
    logic signed [19:0] out_right_reg, out_right_next;
    logic signed [19:0] out_left_reg, out_left_next;
    logic               out_sc_reg, out_sc_next;
    logic               skid_valid_reg, skid_valid_next;
    logic signed [19:0] skid_right_reg, skid_right_next;
    logic signed [19:0] skid_left_reg, skid_left_next;
    logic               skid_sc_reg, skid_sc_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_forward_speed_reg <= 15'h7FFF;
            max_turn_rate_reg     <= 15'h7FFF;
            track_gain_reg        <= 16'd256;
            rpm_gain_reg          <= 24'd65536;
            wheel_rpm_limit_reg   <= 19'h7FFFF;
        end
        else if (cfg_we)
        begin
            unique case (ssm_reg_t'(cfg_index))
                REG_MAX_FORWARD_SPEED: max_forward_speed_reg <= cfg_data[14:0];
                REG_MAX_TURN_RATE:     max_turn_rate_reg     <= cfg_data[14:0];
                REG_TRACK_GAIN:        track_gain_reg        <= cfg_data[15:0];
                REG_RPM_GAIN:          rpm_gain_reg          <= cfg_data[23:0];
                REG_WHEEL_RPM_LIMIT:   wheel_rpm_limit_reg   <= cfg_data[18:0];
                default:               ;
            endcase
        end
    end

    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NUM_STAGES-2:0], in_accept};
        end
    end

    always_comb
    begin
        logic signed [33:0] rq;
        logic signed [33:0] lq;
        logic signed [33:0] fs;
        logic signed [33:0] ds;
        logic [33:0]        ar;
        logic [33:0]        al;
        logic [56:0]        rr;
        logic [56:0]        rl;
        logic [50:0]        half;

        s1_f_next    = ssm_clamp(forward_speed, max_forward_speed_reg);
        s1_t_next    = ssm_clamp(turn_rate, max_turn_rate_reg);

        s2_diff_next = s1_t_reg * $signed({1'b0, track_gain_reg});

        fs           = $signed({{10{s2_f_reg[15]}}, s2_f_reg, 8'h00});
        ds           = $signed({s2_diff_reg[32], s2_diff_reg});
        rq           = fs + ds;
        lq           = fs - ds;
        ar           = rq[33] ? (34'd0 - rq) : rq;
        al           = lq[33] ? (34'd0 - lq) : lq;
        s3_mr_next   = ar[31:0];
        s3_ml_next   = al[31:0];
        s3_nr_next   = rq[33];
        s3_nl_next   = lq[33];

        s4_pr_next   = s3_mr_reg * rpm_gain_reg;
        s4_pl_next   = s3_ml_reg * rpm_gain_reg;

        rr           = {1'b0, s4_pr_reg} + 57'(1 << 23);
        rl           = {1'b0, s4_pl_reg} + 57'(1 << 23);
        s5_rm_next   = rr[55:24];
        s5_lm_next   = rl[55:24];

        s6_big_next  = (s5_rm_reg > s5_lm_reg) ? s5_rm_reg : s5_lm_reg;
        s6_sc_next   = (s6_big_next > {13'd0, wheel_rpm_limit_reg});

        s7_pr_next   = s6_rm_reg * wheel_rpm_limit_reg;
        s7_pl_next   = s6_lm_reg * wheel_rpm_limit_reg;

        half         = {20'd0, s7_big_reg[31:1]};
        if (s7_sc_reg)
        begin
            rr = {6'd0, s7_pr_reg + half};
            rl = {6'd0, s7_pl_reg + half};
            div_d_next = s7_big_reg;
        end
        else
        begin
            rr = {25'd0, s7_rm_reg};
            rl = {25'd0, s7_lm_reg};
            div_d_next = 32'd1;
        end
        div_r_next.rem  = rr[50:19];
        div_r_next.word = rr[18:0];
        div_r_next.neg  = s7_nr_reg;
        div_l_next.rem  = rl[50:19];
        div_l_next.word = rl[18:0];
        div_l_next.neg  = s7_nl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_f_reg    <= s1_f_next;
            s1_t_reg    <= s1_t_next;
            s2_f_reg    <= s1_f_reg;
            s2_diff_reg <= s2_diff_next;
            s3_mr_reg   <= s3_mr_next;
            s3_ml_reg   <= s3_ml_next;
            s3_nr_reg   <= s3_nr_next;
            s3_nl_reg   <= s3_nl_next;
            s4_pr_reg   <= s4_pr_next;
            s4_pl_reg   <= s4_pl_next;
            s4_nr_reg   <= s3_nr_reg;
            s4_nl_reg   <= s3_nl_reg;
            s5_rm_reg   <= s5_rm_next;
            s5_lm_reg   <= s5_lm_next;
            s5_nr_reg   <= s4_nr_reg;
            s5_nl_reg   <= s4_nl_reg;
            s6_rm_reg   <= s5_rm_reg;
            s6_lm_reg   <= s5_lm_reg;
            s6_big_reg  <= s6_big_next;
            s6_sc_reg   <= s6_sc_next;
            s6_nr_reg   <= s5_nr_reg;
            s6_nl_reg   <= s5_nl_reg;
            s7_pr_reg   <= s7_pr_next;
            s7_pl_reg   <= s7_pl_next;
            s7_rm_reg   <= s6_rm_reg;
            s7_lm_reg   <= s6_lm_reg;
            s7_big_reg  <= s6_big_reg;
            s7_sc_reg   <= s6_sc_reg;
            s7_nr_reg   <= s6_nr_reg;
            s7_nl_reg   <= s6_nl_reg;
            div_r_reg[0]  <= div_r_next;
            div_l_reg[0]  <= div_l_next;
            div_d_reg[0]  <= div_d_next;
            div_sc_reg[0] <= s7_sc_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                div_r_reg[k]  <= ssm_div_step(div_r_reg[k-1], div_d_reg[k-1]);
                div_l_reg[k]  <= ssm_div_step(div_l_reg[k-1], div_d_reg[k-1]);
                div_sc_reg[k] <= div_sc_reg[k-1];
            end
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                div_d_reg[k] <= div_d_reg[k-1];
            end
        end
    end

    // apply sign to the final magnitudes
    assign res_right = div_r_reg[DIV_STEPS].neg
                     ? (20'sd0 - $signed({1'b0, div_r_reg[DIV_STEPS].word}))
                     : $signed({1'b0, div_r_reg[DIV_STEPS].word});
    assign res_left  = div_l_reg[DIV_STEPS].neg
                     ? (20'sd0 - $signed({1'b0, div_l_reg[DIV_STEPS].word}))
                     : $signed({1'b0, div_l_reg[DIV_STEPS].word});
    assign res_push  = v_reg[NUM_STAGES-1] && en;
    assign out_take  = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_right_next  = out_right_reg;
        out_left_next   = out_left_reg;
        out_sc_next     = out_sc_reg;
        skid_valid_next = skid_valid_reg;
        skid_right_next = skid_right_reg;
        skid_left_next  = skid_left_reg;
        skid_sc_next    = skid_sc_reg;
        priority if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_right_next  = skid_right_reg;
                out_left_next   = skid_left_reg;
                out_sc_next     = skid_sc_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_push)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_right_next = res_right;
                out_left_next  = res_left;
                out_sc_next    = div_sc_reg[DIV_STEPS];
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_right_next = res_right;
                skid_left_next  = res_left;
                skid_sc_next    = div_sc_reg[DIV_STEPS];
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_right_reg  <= out_right_next;
        out_left_reg   <= out_left_next;
        out_sc_reg     <= out_sc_next;
        skid_right_reg <= skid_right_next;
        skid_left_reg  <= skid_left_next;
        skid_sc_reg    <= skid_sc_next;
    end

    assign out_valid       = out_valid_reg;
    assign right_wheel_rpm = out_right_reg;
    assign left_wheel_rpm  = out_left_reg;
    assign was_scaled      = out_sc_reg;

endmodule

FILE: design/ssm_checker.sv
`timescale 1ns / 1ps
`include "skid_steer_wheel_speed_mixer_macros.svh"

module ssm_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [19:0] right_wheel_rpm,
    input logic signed [19:0] left_wheel_rpm,
    input logic               was_scaled
);

    logic        out_blocked;
    logic        mag_ok;
    logic [40:0] out_word;

    assign out_blocked = out_valid && out_stall;
    assign mag_ok      = (right_wheel_rpm != 20'sh80000) && (left_wheel_rpm != 20'sh80000);
    assign out_word    = {right_wheel_rpm, left_wheel_rpm, was_scaled};

    `SSM_ASSERT_NEXT(a_out_hold, out_blocked, out_valid, "stalled request dropped")
    `SSM_ASSERT_NEXT(a_out_stable, out_blocked, $stable(out_word), "stalled request changed")
    `SSM_ASSERT(a_mag_range, out_valid |-> mag_ok, "wheel magnitude out of range")
    `SSM_ASSERT(a_stall_cause, $rose(in_stall) |-> $past(out_blocked), "stall without cause")
    `SSM_ASSERT(a_stall_out, in_stall |-> out_valid, "input stalled with empty output")

endmodule

bind skid_steer_wheel_speed_mixer ssm_checker u_ssm_checker (.*);
